### sv/gblur_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gblur_pkg: shared types and constants of the 5x5 gaussian blur
// Pixel and window layouts, kernel weights, divider constants and widths.
// ----------------------------------------------------------------------------
package gblur_pkg;

  // frame geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WEFF_W    = COL_W + 1;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 13;
  localparam int LAG_W     = $clog2(2 * MAX_WIDTH + 3);

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // kernel
  localparam int TAPS  = 5;
  localparam int LINES = TAPS - 1;
  localparam int CH_W  = 8;
  localparam int KW_W  = 6;
  localparam logic [KW_W-1:0] KERNEL [TAPS][TAPS] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  // one kernel row sums to at most 107 * 255, the whole kernel to 273 * 255
  localparam int ROWSUM_W = 15;
  localparam int SUM_W    = 17;

  // division by 273 as multiply by ceil(2^32 / 273) and shift
  localparam int DIV_SHIFT = 32;
  localparam int DIV_MUL_W = 24;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 24'd15732481;
  localparam int PROD_W = SUM_W + DIV_MUL_W;

  // cycles from window to lane result
  localparam int LANE_LAT = 3;

  // output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // four previous rows of one column, index 0 is the nearest row
  typedef pixel_t [LINES-1:0] line_t;
  // one vertical column of the window, index 0 is the bottom row
  typedef pixel_t [TAPS-1:0] col_t;
  // the 5x5 window, index 0 is the rightmost column
  typedef col_t [TAPS-1:0] win_t;
  // one channel of the window, [column][row]
  typedef logic [TAPS-1:0][TAPS-1:0][CH_W-1:0] chan_win_t;

  // per-item control traveling with the window
  typedef struct packed {
    logic            emit;
    logic            last;
    logic [TAPS-1:0] row_ok;
    logic [TAPS-1:0] col_ok;
  } tag_t;

endpackage
`default_nettype wire

### sv/gblur_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gblur_window: line store and 5x5 window
// Keeps four rows per column in one wide memory, forms the vertical column
// of each incoming pixel and shifts it into the 5x5 window.
// ----------------------------------------------------------------------------
module gblur_window import gblur_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire pixel_t             px,
  input  wire logic [COL_W-1:0]   col,
  input  wire tag_t               tag_in,
  output logic                    unused_ok,
  output win_t                    win,
  output tag_t                    tag_out
);

  line_t            mem [MAX_WIDTH];
  line_t            rd_mem;
  line_t            byp;
  line_t            rd;
  line_t            wdata;
  col_t             vcol;
  logic             hit;
  logic             s1_valid;
  pixel_t           s1_px;
  logic [COL_W-1:0] s1_col;
  tag_t             s1_tag;

  assign unused_ok = 1'b1;

  // read data, forwarded from the write of the previous word on a match
  assign rd    = hit ? byp : rd_mem;
  assign vcol  = {rd, s1_px};
  assign wdata = vcol[LINES-1:0];

  // line store: read at accept, write back in the following cycle
  always_ff @(posedge clk) begin
    if (push) begin
      rd_mem <= mem[col];
    end
    if (s1_valid) begin
      mem[s1_col] <= wdata;
    end
  end

  // stage one payload and window shift
  always_ff @(posedge clk) begin
    if (push) begin
      hit    <= s1_valid && (s1_col == col);
      byp    <= wdata;
      s1_px  <= px;
      s1_col <= col;
      s1_tag <= tag_in;
    end
    if (s1_valid) begin
      win <= {win[TAPS-2:0], vcol};
    end
  end

  // stage valid and tag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      tag_out  <= '0;
    end else begin
      s1_valid <= push;
      tag_out  <= s1_valid ? s1_tag : '0;
    end
  end

endmodule
`default_nettype wire

### sv/gblur_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gblur_lane: one color channel of the blur
// Masked weighted row sums, total, and division by 273 through a
// reciprocal multiply; three register stages.
// ----------------------------------------------------------------------------
module gblur_lane import gblur_pkg::*; (
  input  wire logic            clk,
  input  wire chan_win_t       taps,
  input  wire tag_t            tag,
  output logic [CH_W-1:0]      level
);

  logic [ROWSUM_W-1:0] row_sum_next [TAPS];
  logic [ROWSUM_W-1:0] row_sum [TAPS];
  logic [SUM_W-1:0]    total_next;
  logic [SUM_W-1:0]    total;
  logic [PROD_W-1:0]   prod;

  // weighted sum of each kernel row, neighbors outside the frame add zero
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      row_sum_next[k] = '0;
      for (int j = 0; j < TAPS; j++) begin
        if (tag.row_ok[k] && tag.col_ok[j]) begin
          row_sum_next[k] = row_sum_next[k] +
                            ROWSUM_W'(taps[j][k]) * ROWSUM_W'(KERNEL[k][j]);
        end
      end
    end
  end

  // total over the rows
  always_comb begin
    total_next = '0;
    for (int k = 0; k < TAPS; k++) begin
      total_next = total_next + SUM_W'(row_sum[k]);
    end
  end

  // pipeline: row sums, total, reciprocal product
  always_ff @(posedge clk) begin
    row_sum <= row_sum_next;
    total   <= total_next;
    prod    <= PROD_W'(total) * PROD_W'(DIV_MUL);
  end

  assign level = prod[DIV_SHIFT +: CH_W];

endmodule
`default_nettype wire

### sv/gblur_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gblur_merge: result assembly and output queue
// Joins the three lane results with the end-of-frame flag, queues them and
// holds back input while every queue slot is spoken for.
// ----------------------------------------------------------------------------
module gblur_merge import gblur_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            reserve,
  input  wire tag_t            tag,
  input  wire logic [CH_W-1:0] red_level,
  input  wire logic [CH_W-1:0] green_level,
  input  wire logic [CH_W-1:0] blue_level,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [CH_W-1:0]      red_out,
  output logic [CH_W-1:0]      green_out,
  output logic [CH_W-1:0]      blue_out,
  output logic                 frame_end
);

  typedef struct packed {
    pixel_t px;
    logic   last;
  } result_t;

  result_t               fifo [FIFO_DEPTH];
  logic [LANE_LAT-1:0]   emit_pipe;
  logic [LANE_LAT-1:0]   last_pipe;
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] fill;
  logic [FIFO_CNT_W-1:0] credit;
  logic                  push;
  logic                  pop;
  result_t               head;

  assign push      = emit_pipe[LANE_LAT-1];
  assign out_valid = (fill != '0);
  assign pop       = out_valid && !out_stall;
  assign full      = (credit == FIFO_CNT_W'(FIFO_DEPTH));

  assign head      = fifo[rd_ptr];
  assign red_out   = head.px.red;
  assign green_out = head.px.green;
  assign blue_out  = head.px.blue;
  assign frame_end = head.last;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{px: '{red: red_level, green: green_level, blue: blue_level},
                        last: last_pipe[LANE_LAT-1]};
    end
  end

  // flag delay matching the lanes, pointers, fill and credit counts
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_pipe <= '0;
      last_pipe <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      fill      <= '0;
      credit    <= '0;
    end else begin
      emit_pipe <= {emit_pipe[LANE_LAT-2:0], tag.emit};
      last_pipe <= {last_pipe[LANE_LAT-2:0], tag.last};
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill   <= fill + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      credit <= credit + FIFO_CNT_W'(reserve) - FIFO_CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

### sv/gaussian_blur_5x5_rgb.sv
`default_nettype none
// A word reaches the output queue through stage one, the window, the row sums, the total and the product.
// Throughput: one item per cycle while the input is not stalled; the line store reads and writes a column a cycle.
// Input stalls only while eight words are queued or in flight toward the output.
// Reset (rst, synchronous) sets width and height to 1024 and restarts the frame;
// the line store is not cleared; words it holds from before the frame are masked out of the sums.
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgb: streaming 5x5 gaussian blur of an rgb frame
// Raster counters, configuration registers and the three channel lanes.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_rgb import gblur_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              kind,
  input  wire logic [CH_W-1:0]   red_in,
  input  wire logic [CH_W-1:0]   green_in,
  input  wire logic [CH_W-1:0]   blue_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CH_W-1:0]        red_out,
  output logic [CH_W-1:0]        green_out,
  output logic [CH_W-1:0]        blue_out,
  output logic                   frame_end,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic KIND_PAD = 1'b1;

  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [COL_W-1:0]    in_col;
  logic [COL_W-1:0]    in_col_next;
  logic [COL_W-1:0]    out_col;
  logic [HEIGHT_W-1:0] out_row;
  logic [LAG_W-1:0]    lag;

  logic [WEFF_W-1:0]   w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [LAG_W-1:0]    lag_target;
  logic                lag_done;
  logic                last;
  logic                in_acc;
  logic                cfg_write;
  reg_idx_t            reg_idx;
  logic                full;
  logic                win_ok;
  pixel_t              px;
  tag_t                tag_in;
  tag_t                tag_win;
  win_t                win;
  chan_win_t           red_taps;
  chan_win_t           green_taps;
  chan_win_t           blue_taps;
  logic [CH_W-1:0]     red_level;
  logic [CH_W-1:0]     green_level;
  logic [CH_W-1:0]     blue_level;
  logic [WEFF_W-1:0]   out_col_ext;
  logic [HEIGHT_W:0]   out_row_ext;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && win_ok;
  assign reg_idx   = reg_idx_t'(paddr[2]);

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // effective frame size
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WEFF_W'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(frame_width);
    end
    h_eff = (frame_height == '0) ? HEIGHT_W'(1) : frame_height;
  end

  // output position and window masks
  assign lag_target  = LAG_W'({w_eff, 1'b0}) + LAG_W'(2);
  assign lag_done    = (lag == lag_target);
  assign out_col_ext = WEFF_W'(out_col);
  assign out_row_ext = (HEIGHT_W + 1)'(out_row);
  assign last        = lag_done && (out_row == h_eff - 1'b1) &&
                       (out_col_ext == w_eff - 1'b1);

  always_comb begin
    tag_in.emit      = lag_done;
    tag_in.last      = last;
    tag_in.row_ok[0] = (out_row_ext + 2'd2) < (HEIGHT_W + 1)'(h_eff);
    tag_in.row_ok[1] = (out_row_ext + 2'd1) < (HEIGHT_W + 1)'(h_eff);
    tag_in.row_ok[2] = 1'b1;
    tag_in.row_ok[3] = (out_row != '0);
    tag_in.row_ok[4] = (out_row > HEIGHT_W'(1));
    tag_in.col_ok[0] = (out_col_ext + 2'd2) < w_eff;
    tag_in.col_ok[1] = (out_col_ext + 2'd1) < w_eff;
    tag_in.col_ok[2] = 1'b1;
    tag_in.col_ok[3] = (out_col != '0);
    tag_in.col_ok[4] = (out_col > COL_W'(1));
  end

  // input word, pad items enter as black
  assign in_stall = full;
  assign in_acc   = in_valid && !in_stall;
  assign px       = (kind == KIND_PAD) ? '0 :
                    '{red: red_in, green: green_in, blue: blue_in};

  // input column wraps at the row end and restarts with the frame
  assign in_col_next = (last || (WEFF_W'(in_col) + 1'b1 == w_eff)) ? '0 : in_col + 1'b1;

  // registers and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_W'(1024);
      frame_height <= HEIGHT_W'(1024);
      in_col       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      lag          <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[HEIGHT_W-1:0];
        default:          ;
      endcase
      in_col  <= '0;
      out_col <= '0;
      out_row <= '0;
      lag     <= '0;
    end else if (in_acc) begin
      in_col <= in_col_next;
      if (!lag_done) begin
        lag <= lag + 1'b1;
      end else if (last) begin
        out_col <= '0;
        out_row <= '0;
        lag     <= '0;
      end else if (out_col_ext + 1'b1 == w_eff) begin
        out_col <= '0;
        out_row <= out_row + 1'b1;
      end else begin
        out_col <= out_col + 1'b1;
      end
    end
  end

  gblur_window u_window (
    .clk       (clk),
    .rst       (rst),
    .push      (in_acc),
    .px        (px),
    .col       (in_col),
    .tag_in    (tag_in),
    .unused_ok (win_ok),
    .win       (win),
    .tag_out   (tag_win)
  );

  // split the window into channels
  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      for (int k = 0; k < TAPS; k++) begin
        red_taps[j][k]   = win[j][k].red;
        green_taps[j][k] = win[j][k].green;
        blue_taps[j][k]  = win[j][k].blue;
      end
    end
  end

  gblur_lane u_lane_red (
    .clk   (clk),
    .taps  (red_taps),
    .tag   (tag_win),
    .level (red_level)
  );

  gblur_lane u_lane_green (
    .clk   (clk),
    .taps  (green_taps),
    .tag   (tag_win),
    .level (green_level)
  );

  gblur_lane u_lane_blue (
    .clk   (clk),
    .taps  (blue_taps),
    .tag   (tag_win),
    .level (blue_level)
  );

  gblur_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .reserve     (in_acc && lag_done),
    .tag         (tag_win),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .full        (full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .frame_end   (frame_end)
  );

endmodule
`default_nettype wire

### tb/gblur_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gblur_checker: predicts and checks the blurred pixel stream
// Watches the pixel, blurred word and register channels. It keeps its own line
// store, raster counters and register copies, works out every blurred word when
// a pixel word is taken, and checks the outgoing words field by field in order.
// ----------------------------------------------------------------------------
module gblur_checker import gblur_pkg::*; #(
  parameter logic [ADDR_W-1:0] WIDTH_REG_ADDR  = '0,
  parameter logic [ADDR_W-1:0] HEIGHT_REG_ADDR = '0,
  parameter logic              PAD_KIND        = 1'b1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic              kind,
  input  wire logic [CH_W-1:0]   red_in,
  input  wire logic [CH_W-1:0]   green_in,
  input  wire logic [CH_W-1:0]   blue_in,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [CH_W-1:0]   red_out,
  input  wire logic [CH_W-1:0]   green_out,
  input  wire logic [CH_W-1:0]   blue_out,
  input  wire logic              frame_end,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  input  wire logic [DATA_W-1:0] prdata,
  input  wire logic              pready,
  output int                     fail_total,
  output int                     pending_words,
  output int                     words_checked
);

  localparam int unsigned ROW_SLOTS    = 8;
  localparam int unsigned WEIGHT_TOTAL = 273;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } blur_word_t;

  // rows kept in slot row mod 8, the window is read straight from them
  logic [3*CH_W-1:0]   line_mem [ROW_SLOTS][MAX_WIDTH];
  blur_word_t          expected_blur [$];
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  int                  in_col, in_row, out_col, out_row, lag;
  int                  fails, checked;

  function automatic int active_width();
    int w;
    w = int'(width_reg);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = int'(height_reg);
    if (h == 0) h = 1;
    return h;
  endfunction

  // kernel is symmetric, so the weight only depends on the two distances
  function automatic int tap_weight(input int dr, input int dc);
    int a, b, t;
    a = (dr < 0) ? -dr : dr;
    b = (dc < 0) ? -dc : dc;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    if (a == 0 && b == 0) return 41;
    if (a == 0 && b == 1) return 26;
    if (a == 0 && b == 2) return 7;
    if (a == 1 && b == 1) return 16;
    if (a == 1 && b == 2) return 4;
    return 1;
  endfunction

  task automatic restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    lag     = 0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  // store the pixel, then work out the blurred word it completes, if any
  task automatic take_pixel(input logic k, input logic [CH_W-1:0] r, g, b);
    int                w, h, row, col, wt, dr, dc;
    int unsigned       sum_r, sum_g, sum_b;
    logic [3*CH_W-1:0] px;
    blur_word_t        word;
    w = active_width();
    h = active_height();
    // pad inside the frame stores black, anything past the frame is not stored
    if (in_row < h && in_col < w) begin
      line_mem[in_row % ROW_SLOTS][in_col] = (k == PAD_KIND) ? '0 : {r, g, b};
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (lag < 2 * w + 2) begin
      lag++;
      return;
    end
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    // neighbours outside the frame add nothing
    for (dr = -2; dr <= 2; dr++) begin
      for (dc = -2; dc <= 2; dc++) begin
        row = out_row + dr;
        col = out_col + dc;
        if (row < 0 || row >= h || col < 0 || col >= w) continue;
        px = line_mem[row % ROW_SLOTS][col];
        wt = tap_weight(dr, dc);
        sum_r += wt * px[3*CH_W-1:2*CH_W];
        sum_g += wt * px[2*CH_W-1:CH_W];
        sum_b += wt * px[CH_W-1:0];
      end
    end
    word.red   = CH_W'(sum_r / WEIGHT_TOTAL);
    word.green = CH_W'(sum_g / WEIGHT_TOTAL);
    word.blue  = CH_W'(sum_b / WEIGHT_TOTAL);
    word.last  = (out_row == h - 1) && (out_col == w - 1);
    expected_blur.insert(expected_blur.size(), word);
    if (word.last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic check_word();
    blur_word_t want;
    if (expected_blur.size() == 0) begin
      report_mismatch("blurred word with nothing expected", {red_out, green_out, blue_out}, 0);
    end else begin
      want = expected_blur.pop_front();
      checked++;
      if (red_out !== want.red) report_mismatch("red_out", red_out, want.red);
      if (green_out !== want.green) report_mismatch("green_out", green_out, want.green);
      if (blue_out !== want.blue) report_mismatch("blue_out", blue_out, want.blue);
      if (frame_end !== want.last) report_mismatch("frame_end", frame_end, want.last);
    end
  endtask

  // register writes restart the frame, reads return the raw register
  task automatic watch_registers();
    if (pwrite) begin
      if (paddr == WIDTH_REG_ADDR) begin
        width_reg = pwdata[WIDTH_W-1:0];
        restart_frame();
      end else if (paddr == HEIGHT_REG_ADDR) begin
        height_reg = pwdata[HEIGHT_W-1:0];
        restart_frame();
      end
    end else if (paddr == WIDTH_REG_ADDR) begin
      if (prdata !== DATA_W'(width_reg)) report_mismatch("frame_width read", prdata, width_reg);
    end else if (paddr == HEIGHT_REG_ADDR) begin
      if (prdata !== DATA_W'(height_reg)) report_mismatch("frame_height read", prdata, height_reg);
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      width_reg  = WIDTH_W'(1024);
      height_reg = HEIGHT_W'(1024);
      restart_frame();
      expected_blur.delete();
    end else begin
      if (in_valid && !in_stall) take_pixel(kind, red_in, green_in, blue_in);
      if (out_valid && !out_stall) check_word();
      if (psel && penable && pready) watch_registers();
    end
    pending_words <= expected_blur.size();
    fail_total    <= fails;
    words_checked <= checked;
  end

endmodule

### tb/gaussian_blur_5x5_rgb_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgb_tb: stimulus and verdict for the 5x5 rgb blur
// Programs frame sizes over the register port and streams frames of random
// pixels with pads and cut-short frames, with random gaps on both channels.
// A checker beside the block predicts and compares every blurred word.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_rgb_tb import gblur_pkg::*;;

  localparam logic [ADDR_W-1:0] WIDTH_REG_ADDR  = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] HEIGHT_REG_ADDR = ADDR_W'(4);
  localparam logic              KIND_PIXEL      = 1'b0;
  localparam logic              KIND_PAD        = 1'b1;
  localparam int                WIDEST_FIELD    = (1 << WIDTH_W) - 1;
  localparam int                TALLEST         = 4096;
  localparam int                ITEM_BUDGET     = 1050;
  localparam int                MAX_GAP         = 18;
  localparam int                DRAIN_CYCLES    = 32;
  localparam int                CYCLE_LIMIT     = 4000000;

  typedef enum int {TONE_RANDOM, TONE_BINARY, TONE_WHITE} tone_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              kind;
  logic [CH_W-1:0]   red_in;
  logic [CH_W-1:0]   green_in;
  logic [CH_W-1:0]   blue_in;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CH_W-1:0]   red_out;
  logic [CH_W-1:0]   green_out;
  logic [CH_W-1:0]   blue_out;
  logic              frame_end;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_total, pending_words, words_checked;
  int items_sent, frames_sent, settings_made;
  int cur_w, cur_h, max_w, max_h, cycle_count, stall_left;
  bit quiet;

  gaussian_blur_5x5_rgb dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out), .frame_end(frame_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gblur_checker #(
    .WIDTH_REG_ADDR(WIDTH_REG_ADDR), .HEIGHT_REG_ADDR(HEIGHT_REG_ADDR), .PAD_KIND(KIND_PAD)
  ) blur_monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out), .frame_end(frame_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_total(fail_total), .pending_words(pending_words), .words_checked(words_checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [CH_W-1:0] draw_channel(input tone_t tone);
    case (tone)
      TONE_BINARY: return $urandom_range(0, 1) ? '1 : '0;
      TONE_WHITE:  return '1;
      default:     return CH_W'($urandom());
    endcase
  endfunction

  // output side holds stall for a drawn number of cycles after each word
  always @(posedge clk) begin : out_pacing
    int hold;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (out_valid && !out_stall) begin
      hold = draw_gap();
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end
  end

  // one pixel word, valid stays high when the next word follows at once
  task automatic send_item(input logic k, input logic [CH_W-1:0] r, g, b);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_trailing(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_item($urandom_range(0, 1) ? KIND_PAD : KIND_PIXEL,
                CH_W'($urandom()), CH_W'($urandom()), CH_W'($urandom()));
    end
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_reg(input logic [ADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every expected word is out and the pipeline has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // new frame size, written in random order, sometimes with junk above the field
  task automatic configure(input int w, input int h);
    logic [DATA_W-1:0] wdata, hdata;
    settle();
    wdata = DATA_W'(w);
    hdata = DATA_W'(h);
    if ($urandom_range(0, 3) == 0) wdata = wdata | ($urandom() << WIDTH_W);
    if ($urandom_range(0, 3) == 0) hdata = hdata | ($urandom() << HEIGHT_W);
    if ($urandom_range(0, 1)) begin
      write_reg(WIDTH_REG_ADDR, wdata);
      write_reg(HEIGHT_REG_ADDR, hdata);
    end else begin
      write_reg(HEIGHT_REG_ADDR, hdata);
      write_reg(WIDTH_REG_ADDR, wdata);
    end
    if ($urandom_range(0, 1)) begin
      read_reg(WIDTH_REG_ADDR);
      read_reg(HEIGHT_REG_ADDR);
    end
    cur_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    cur_h = (h == 0) ? 1 : h;
    if (cur_w > max_w) max_w = cur_w;
    if (cur_h > max_h) max_h = cur_h;
    settings_made++;
  endtask

  // frame pixels with occasional pads, then the flush words; a broken frame stops early
  task automatic send_frame(input bit broken, input int cut_cap);
    int    pixels, total, n, i;
    logic  k;
    tone_t tone;
    pixels = cur_w * cur_h;
    total  = pixels + 2 * cur_w + 2;
    n      = broken ? $urandom_range(0, (total - 1 < cut_cap) ? total - 1 : cut_cap) : total;
    tone   = tone_t'($urandom_range(0, 2));
    for (i = 0; i < n; i++) begin
      if (i < pixels) k = ($urandom_range(0, 15) == 0) ? KIND_PAD : KIND_PIXEL;
      else k = $urandom_range(0, 1) ? KIND_PAD : KIND_PIXEL;
      send_item(k, draw_channel(tone), draw_channel(tone), draw_channel(tone));
    end
    if (!broken) frames_sent++;
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped after %0d cycles with %0d words outstanding",
             cycle_count, pending_words);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int  w, h, nframes, f;
    bit  wide_done, tall_done;
    rst       = 1'b1;
    in_valid  = 1'b0;
    kind      = KIND_PIXEL;
    red_in    = '0;
    green_in  = '0;
    blue_in   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    quiet     = 1'b0;
    wide_done = 1'b0;
    tall_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of both registers
    read_reg(WIDTH_REG_ADDR);
    read_reg(HEIGHT_REG_ADDR);

    // 3x2 frame: full scale and black, a pad inside the frame, random pixel and pad words as flush
    configure(3, 2);
    send_item(KIND_PIXEL, '1, '1, '1);
    send_item(KIND_PIXEL, '0, '0, '0);
    send_item(KIND_PAD, '1, '1, '1);
    send_item(KIND_PIXEL, '1, '0, 8'h80);
    send_item(KIND_PIXEL, '0, '1, 8'h01);
    send_item(KIND_PIXEL, '1, '1, '1);
    send_trailing(8);

    // zero width and height act as a single pixel frame
    configure(0, 0);
    send_item(KIND_PIXEL, '1, '1, '1);
    send_trailing(4);

    // one column, three rows
    configure(1, 3);
    send_item(KIND_PIXEL, '1, '1, '1);
    send_item(KIND_PAD, '1, '0, '1);
    send_item(KIND_PIXEL, '0, '0, '0);
    send_trailing(4);

    // random phases of small frames, with cut-short wide and tall frames mixed in
    while (items_sent < ITEM_BUDGET) begin
      if (!wide_done && items_sent >= ITEM_BUDGET / 3) begin
        wide_done = 1'b1;
        quiet = $urandom_range(0, 1);
        configure(MAX_WIDTH, 2);
        send_frame(1'b1, 300);
        configure(WIDEST_FIELD, 1);
        send_frame(1'b1, 300);
      end
      if (!tall_done && items_sent >= 2 * ITEM_BUDGET / 3) begin
        tall_done = 1'b1;
        quiet = $urandom_range(0, 1);
        configure(1, TALLEST);
        send_frame(1'b1, 300);
      end
      quiet = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) w = 0;
      if ($urandom_range(0, 19) == 0) h = 0;
      configure(w, h);
      nframes = $urandom_range(1, 3);
      for (f = 0; f < nframes; f++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_frame(1'b1, 1000);
          break;
        end
        send_frame(1'b0, 0);
      end
    end

    settle();
    $display("sent %0d pixel words in %0d complete frames over %0d frame sizes",
             items_sent, frames_sent, settings_made);
    $display("checked %0d blurred words, widths up to %0d, heights up to %0d",
             words_checked, max_w, max_h);
    if (fail_total == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/gblur_pkg.sv
sv/gblur_window.sv
sv/gblur_lane.sv
sv/gblur_merge.sv
sv/gaussian_blur_5x5_rgb.sv
tb/gblur_checker.sv
tb/gaussian_blur_5x5_rgb_tb.sv
